// File: hw/rtl/v3a_pkg.sv
// shared types, constants and helpers of the three-component vector alu
`default_nettype none
package v3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = 32 + FRAC_BITS;  // dividend and quotient width
  localparam int SQ_STAGES = 32;              // one root bit per stage
  localparam int IN_W      = 232;
  localparam int OUT_W     = 128;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_SCALE = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_MAG   = 4'd4,
    CMD_DOT   = 4'd5,
    CMD_NORM  = 4'd6,
    CMD_CROSS = 4'd7,
    CMD_EQUAL = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      s;
  } op_t;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [2:0]       neg;
    logic [2:0][31:0] num;
    logic [31:0]      abs_s;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             eq;
    logic             dz;
  } ctx_t;

  // saturate a wide signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = {34'd0, 32'h7FFF_FFFF};
    lo = {{34{1'b1}}, 32'h8000_0000};
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [65:0] sext32(input logic [31:0] v);
    sext32 = $signed({{34{v[31]}}, v});
  endfunction

  function automatic logic signed [65:0] sext64(input logic [63:0] v);
    sext64 = $signed({{2{v[63]}}, v});
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vector3_alu_core.sv
// top level of the three-component vector alu: lanes, merge, root and divide pipelines
//
//  channel  | dir | handshake                   | content
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | cmd, a, b, scalar_in
//  m_axis   | out | m_axis_tvalid/m_axis_tready | r_x, r_y, r_z, scalar_out; flags in tuser
//
// one item per cycle unless the output stalls; an item passes the input, operand and
// merge registers, the 32-stage square root, the NUM_W-stage divider and the output
// register. the whole pipeline advances together; it holds only when the output
// register is full and m_axis_tready is low. reset clears the valid bits only.
`default_nettype none
module vector3_alu_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // cmd, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in; zero pad to 232 bits
  input  wire logic [v3a_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // r_x, r_y, r_z, scalar_out
  output logic      [v3a_pkg::OUT_W-1:0]  m_axis_tdata,
  // equal_flag, div_zero
  output logic      [1:0]                 m_axis_tuser
);
  import v3a_pkg::*;

  logic en;
  op_t  in_q, ops_q;
  logic in_v_q, ops_v_q, mrg_v_q, out_v_q;
  logic [SQ_STAGES-1:0] sq_v_q;
  logic [NUM_W-1:0]     dv_v_q;
  logic [2:0][63:0] p0, p1;
  ctx_t        mrg_ctx;
  logic [63:0] sumsq;
  logic [31:0] root;
  ctx_t        sq_ctx_q [SQ_STAGES];
  ctx_t        dv_ctx_q [NUM_W];
  ctx_t        sq_out;
  logic [31:0] den;
  logic [2:0][NUM_W-1:0] quo;
  ctx_t        fin;
  logic [OUT_W-1:0] out_data_d, out_data_q;
  logic [1:0]       out_user_d, out_user_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      ops_v_q <= 1'b0;
      mrg_v_q <= 1'b0;
      sq_v_q  <= '0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      in_v_q  <= s_axis_tvalid;
      ops_v_q <= in_v_q;
      mrg_v_q <= ops_v_q;
      sq_v_q  <= {sq_v_q[SQ_STAGES-2:0], mrg_v_q};
      dv_v_q  <= {dv_v_q[NUM_W-2:0], sq_v_q[SQ_STAGES-1]};
      out_v_q <= dv_v_q[NUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q.cmd  <= s_axis_tdata[3:0];
      in_q.a[0] <= s_axis_tdata[35:4];
      in_q.a[1] <= s_axis_tdata[67:36];
      in_q.a[2] <= s_axis_tdata[99:68];
      in_q.b[0] <= s_axis_tdata[131:100];
      in_q.b[1] <= s_axis_tdata[163:132];
      in_q.b[2] <= s_axis_tdata[195:164];
      in_q.s    <= s_axis_tdata[227:196];
      ops_q     <= in_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .cmd_i (in_q.cmd),
      .a_i   (in_q.a[i]),
      .b_i   (in_q.b[i]),
      .s_i   (in_q.s),
      .ca0_i (in_q.a[(i+1)%3]),
      .cb0_i (in_q.b[(i+2)%3]),
      .ca1_i (in_q.a[(i+2)%3]),
      .cb1_i (in_q.b[(i+1)%3]),
      .p0_o  (p0[i]),
      .p1_o  (p1[i])
    );
  end

  v3a_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .op_i    (ops_q),
    .p0_i    (p0),
    .p1_i    (p1),
    .ctx_o   (mrg_ctx),
    .sumsq_o (sumsq)
  );

  v3a_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (sumsq),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_ctx_q[0] <= mrg_ctx;
      for (int k = 1; k < SQ_STAGES; k++) sq_ctx_q[k] <= sq_ctx_q[k-1];
      dv_ctx_q[0] <= sq_out;
      for (int k = 1; k < NUM_W; k++) dv_ctx_q[k] <= dv_ctx_q[k-1];
    end
  end

  // magnitude result and normalize zero check once the root is known
  always_comb begin
    sq_out = sq_ctx_q[SQ_STAGES-1];
    if (sq_out.cmd == CMD_MAG) begin
      sq_out.sc = root[31] ? 32'h7FFF_FFFF : root;
    end
    if (sq_out.cmd == CMD_NORM) begin
      sq_out.dz = (root == 32'd0);
    end
    den = (sq_out.cmd == CMD_NORM) ? root : sq_out.abs_s;
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (sq_out.num[i]),
      .den_i (den),
      .q_o   (quo[i])
    );
  end

  always_comb begin
    fin = dv_ctx_q[NUM_W-1];
    if ((fin.cmd == CMD_DIV || fin.cmd == CMD_NORM) && !fin.dz) begin
      for (int i = 0; i < 3; i++) begin
        if (fin.neg[i]) begin
          if ((|quo[i][NUM_W-1:32]) || (quo[i][31] && (|quo[i][30:0]))) begin
            fin.r[i] = 32'h8000_0000;
          end else begin
            fin.r[i] = 32'(-quo[i][31:0]);
          end
        end else begin
          fin.r[i] = (|quo[i][NUM_W-1:31]) ? 32'h7FFF_FFFF : quo[i][31:0];
        end
      end
    end
    out_data_d = {fin.sc, fin.r[2], fin.r[1], fin.r[0]};
    out_user_d = {fin.dz, fin.eq};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
endmodule
`default_nettype wire

// File: hw/rtl/v3a_lane.sv
// one vector lane: two registered signed 32x32 multipliers with operand select
`default_nettype none
module v3a_lane (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] s_i,
  input  wire logic [31:0] ca0_i,
  input  wire logic [31:0] cb0_i,
  input  wire logic [31:0] ca1_i,
  input  wire logic [31:0] cb1_i,
  output logic      [63:0] p0_o,
  output logic      [63:0] p1_o
);
  import v3a_pkg::*;

  logic [31:0] x0, y0;
  logic [63:0] p0_d, p1_d;
  logic [63:0] p0_q, p1_q;

  always_comb begin
    unique case (cmd_i)
      CMD_CROSS: begin x0 = ca0_i; y0 = cb0_i; end
      CMD_SCALE: begin x0 = a_i;   y0 = s_i;   end
      CMD_DOT:   begin x0 = a_i;   y0 = b_i;   end
      default:   begin x0 = a_i;   y0 = a_i;   end
    endcase
    p0_d = 64'($signed(x0) * $signed(y0));
    p1_d = 64'($signed(ca1_i) * $signed(cb1_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
  end

  assign p0_o = p0_q;
  assign p1_o = p1_q;
endmodule
`default_nettype wire

// File: hw/rtl/v3a_merge.sv
// merge stage: combines lane products, adds, compares and prepares divide operands
`default_nettype none
module v3a_merge (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire v3a_pkg::op_t      op_i,
  input  wire logic [2:0][63:0]  p0_i,
  input  wire logic [2:0][63:0]  p1_i,
  output v3a_pkg::ctx_t          ctx_o,
  output logic      [63:0]       sumsq_o
);
  import v3a_pkg::*;

  ctx_t        ctx_d, ctx_q;
  logic [63:0] sumsq_d, sumsq_q;
  logic signed [65:0] dot;

  always_comb begin
    ctx_d     = '0;
    ctx_d.cmd = op_i.cmd;
    ctx_d.abs_s = op_i.s[31] ? 32'(-op_i.s) : op_i.s;
    sumsq_d   = p0_i[0] + p0_i[1] + p0_i[2];
    dot = sext64(p0_i[0]) + sext64(p0_i[1]) + sext64(p0_i[2]);
    for (int i = 0; i < 3; i++) begin
      ctx_d.num[i] = op_i.a[i][31] ? 32'(-op_i.a[i]) : op_i.a[i];
      // normalize divides by a positive magnitude
      ctx_d.neg[i] = (op_i.cmd == CMD_NORM) ? op_i.a[i][31]
                                            : (op_i.a[i][31] ^ op_i.s[31]);
    end
    unique case (op_i.cmd)
      CMD_ADD: begin
        for (int i = 0; i < 3; i++) ctx_d.r[i] = sat32(sext32(op_i.a[i]) + sext32(op_i.b[i]));
      end
      CMD_SUB: begin
        for (int i = 0; i < 3; i++) ctx_d.r[i] = sat32(sext32(op_i.a[i]) - sext32(op_i.b[i]));
      end
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) ctx_d.r[i] = sat32(sext64(p0_i[i]) >>> FRAC_BITS);
      end
      CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          ctx_d.r[i] = sat32((sext64(p0_i[i]) - sext64(p1_i[i])) >>> FRAC_BITS);
        end
      end
      CMD_DOT:   ctx_d.sc = sat32(dot >>> FRAC_BITS);
      CMD_EQUAL: ctx_d.eq = (op_i.a == op_i.b);
      CMD_DIV:   ctx_d.dz = (op_i.s == 32'd0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q   <= ctx_d;
      sumsq_q <= sumsq_d;
    end
  end

  assign ctx_o   = ctx_q;
  assign sumsq_o = sumsq_q;
endmodule
`default_nettype wire

// File: hw/rtl/v3a_isqrt.sv
// pipelined integer square root of a 64-bit value, one root bit per stage
`default_nettype none
module v3a_isqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] n_i,
  output logic      [31:0] root_o
);
  import v3a_pkg::*;

  logic [63:0] n_q    [SQ_STAGES];
  logic [33:0] rem_q  [SQ_STAGES];
  logic [31:0] root_q [SQ_STAGES];
  logic [63:0] n_d    [SQ_STAGES];
  logic [33:0] rem_d  [SQ_STAGES];
  logic [31:0] root_d [SQ_STAGES];

  always_comb begin
    logic [63:0] np;
    logic [33:0] rp;
    logic [31:0] qp;
    logic [35:0] rext, trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        np = n_i; rp = '0; qp = '0;
      end else begin
        np = n_q[k-1]; rp = rem_q[k-1]; qp = root_q[k-1];
      end
      rext  = {rp, np[63:62]};
      trial = {2'b00, qp, 2'b01};
      if (rext >= trial) begin
        rem_d[k]  = 34'(rext - trial);
        root_d[k] = {qp[30:0], 1'b1};
      end else begin
        rem_d[k]  = rext[33:0];
        root_d[k] = {qp[30:0], 1'b0};
      end
      n_d[k] = {np[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q[SQ_STAGES-1];
endmodule
`default_nettype wire

// File: hw/rtl/v3a_div.sv
// pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage
`default_nettype none
module v3a_div (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [31:0]               num_i,
  input  wire logic [31:0]               den_i,
  output logic      [v3a_pkg::NUM_W-1:0] q_o
);
  import v3a_pkg::*;

  logic [NUM_W-1:0] dvd_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [31:0]      rem_q [NUM_W];
  logic [31:0]      den_q [NUM_W];
  logic [NUM_W-1:0] dvd_d [NUM_W];
  logic [NUM_W-1:0] quo_d [NUM_W];
  logic [31:0]      rem_d [NUM_W];
  logic [31:0]      den_d [NUM_W];

  always_comb begin
    logic [NUM_W-1:0] dp, qp;
    logic [31:0]      rp, dn;
    logic [32:0]      rext;
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        dp = {num_i, {FRAC_BITS{1'b0}}}; qp = '0; rp = '0; dn = den_i;
      end else begin
        dp = dvd_q[k-1]; qp = quo_q[k-1]; rp = rem_q[k-1]; dn = den_q[k-1];
      end
      rext = {rp, dp[NUM_W-1]};
      if (rext >= {1'b0, dn}) begin
        rem_d[k] = 32'(rext - {1'b0, dn});
        quo_d[k] = {qp[NUM_W-2:0], 1'b1};
      end else begin
        rem_d[k] = rext[31:0];
        quo_d[k] = {qp[NUM_W-2:0], 1'b0};
      end
      dvd_d[k] = {dp[NUM_W-2:0], 1'b0};
      den_d[k] = dn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q <= dvd_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
      den_q <= den_d;
    end
  end

  assign q_o = quo_q[NUM_W-1];
endmodule
`default_nettype wire
